// ===== rtl/ctaphid_packet_reassembler_defines.svh =====
// Assertion macros for the reassembler.
`ifndef CTAPHID_PACKET_REASSEMBLER_DEFINES_SVH
`define CTAPHID_PACKET_REASSEMBLER_DEFINES_SVH

`ifndef SYNTHESIS
`define CPR_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("reassembler check failed");
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("reassembler check failed");
`else
`define CPR_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

// ===== rtl/cpr_pkg.sv =====
package cpr_pkg;

  localparam int DEF_CHANNEL_SLOTS = 4;
  localparam int DEF_BUFFER_BYTES  = 1280;
  localparam int POS_W             = 6;   // 64-byte packets
  localparam int HDR_W             = 56;
  localparam int IN_DATA_W         = 24;
  localparam int OUT_DATA_W        = 64;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [POS_W-1:0] POS_CONT_HDR = 6'd4;
  localparam logic [POS_W-1:0] POS_INIT_HDR = 6'd6;
  localparam logic [POS_W-1:0] POS_CONT_DATA = 6'd5;
  localparam logic [POS_W-1:0] POS_INIT_DATA = 6'd7;
  localparam logic [POS_W-1:0] POS_LAST = 6'd63;

  // input actions (tuser)
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // result kinds (tuser)
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_LENGTH = 2'd0;
  localparam logic [1:0] ERR_BUSY   = 2'd1;
  localparam logic [1:0] ERR_SEQ    = 2'd2;

  // configuration register byte address bit for index
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    DEC_NONE,
    DEC_INIT,
    DEC_CONT,
    DEC_ERROR
  } cpr_dec_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic pre;
    logic find;
    logic alloc;
    logic cont_dec;
    logic commit;
    logic busy;
    logic emit_read;
    logic emit_end;
  } cpr_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       need_dec;
    logic       is_end;
    logic       is_init;
    logic       cid_zero;
    logic       len_over;
    logic       found_now;
    logic       picked_now;
    logic       alloc_stop;
    logic       out_free;
  } cpr_stat_t;

endpackage

// ===== rtl/cpr_ctrl.sv =====
module cpr_ctrl #(
  parameter int CHANNEL_SLOTS = cpr_pkg::DEF_CHANNEL_SLOTS,
  parameter int SW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cpr_pkg::cpr_stat_t stat,
  output cpr_pkg::cpr_cmd_t  cmd,
  output logic [SW-1:0]     idx
);
  import cpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_PRE, S_FIND, S_ALLOC, S_CONT, S_COMMIT, S_READ, S_END
  } state_t;

  localparam logic [SW-1:0] IDX_LAST = SW'(CHANNEL_SLOTS - 1);

  state_t        state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          idx_at_last;

  assign idx_at_last = (idx_r == IDX_LAST);
  assign idx         = idx_r;
  assign in_tready   = (state_r == S_IDLE);

  // commands follow the state
  always_comb begin
    cmd           = '0;
    cmd.take      = (state_r == S_IDLE) && in_tvalid;
    cmd.exec      = (state_r == S_EXEC);
    cmd.pre       = (state_r == S_PRE);
    cmd.find      = (state_r == S_FIND);
    cmd.alloc     = (state_r == S_ALLOC);
    cmd.cont_dec  = (state_r == S_CONT);
    cmd.commit    = (state_r == S_COMMIT);
    cmd.busy      = (state_r == S_ALLOC) && idx_at_last && !stat.alloc_stop &&
                    !stat.picked_now;
    cmd.emit_read = (state_r == S_READ) && stat.out_free;
    cmd.emit_end  = (state_r == S_END) && stat.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: begin
        case (stat.act)
          ACT_READ: state_nxt = S_READ;
          ACT_BYTE: begin
            if (stat.need_dec) state_nxt = S_PRE;
            else if (stat.is_end) state_nxt = S_END;
            else state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_PRE: begin
        if (stat.cid_zero || (stat.is_init && stat.len_over)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FIND;
          idx_nxt   = '0;
        end
      end
      S_FIND: begin
        if (idx_at_last) begin
          idx_nxt = '0;
          if (!stat.is_init) state_nxt = S_CONT;
          else if (stat.found_now) state_nxt = S_COMMIT;
          else state_nxt = S_ALLOC;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_ALLOC: begin
        if (stat.alloc_stop) state_nxt = S_COMMIT;
        else if (idx_at_last) state_nxt = stat.picked_now ? S_COMMIT : S_IDLE;
        else idx_nxt = idx_r + 1'b1;
      end
      S_CONT:   state_nxt = S_IDLE;
      S_COMMIT: state_nxt = S_IDLE;
      S_READ:   if (stat.out_free) state_nxt = S_IDLE;
      S_END:    if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/cpr_dp.sv =====
module cpr_dp #(
  parameter int CHANNEL_SLOTS = cpr_pkg::DEF_CHANNEL_SLOTS,
  parameter int BUFFER_BYTES  = cpr_pkg::DEF_BUFFER_BYTES,
  parameter int SW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cpr_pkg::cpr_cmd_t                cmd,
  input  logic [SW-1:0]                    idx,
  output cpr_pkg::cpr_stat_t               stat,
  input  logic [cpr_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                       in_tuser,
  input  logic [15:0]                      idle_timeout,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cpr_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [1:0]                       out_tuser
);
  import cpr_pkg::*;

  localparam int LW    = $clog2(BUFFER_BYTES + 1);
  localparam int CW    = (LW > 16) ? LW : 16;
  localparam int DEPTH = CHANNEL_SLOTS * BUFFER_BYTES;
  localparam int AW    = $clog2(DEPTH);

  // latched item
  logic [1:0]  act_r;
  logic [7:0]  byte_r;
  logic [1:0]  rslot_r;
  logic [10:0] roff_r;

  // packet state
  logic [POS_W-1:0] pos_r;
  logic [HDR_W-1:0] hdr_r, hdr_shift;
  logic             pend_init_r;
  cpr_dec_t         dec_r;
  logic [SW-1:0]    dslot_r;
  logic [1:0]       derr_r;
  logic [31:0]      dch_r;
  logic [31:0]      now_r;

  // scan state
  logic          found_r, picked_r;
  logic [SW-1:0] hit_r, pick_r, target;

  // channel table
  logic          act_slot_r [CHANNEL_SLOTS];
  logic [31:0]   id_r       [CHANNEL_SLOTS];
  logic [6:0]    cmd_r      [CHANNEL_SLOTS];
  logic [LW-1:0] total_r    [CHANNEL_SLOTS];
  logic [LW-1:0] rx_r       [CHANNEL_SLOTS];
  logic [7:0]    seq_r      [CHANNEL_SLOTS];
  logic [31:0]   last_r     [CHANNEL_SLOTS];

  // payload store
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          rd_ok_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;

  // output register
  logic                  out_valid_r;
  logic [1:0]            out_kind_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [31:0]   cid_cur;
  logic [6:0]    cmd_cur;
  logic [15:0]   bcnt_cur;
  logic [7:0]    seq_cur;
  logic          idx_match, idx_expired;
  logic [31:0]   idle_age;
  logic          store_en;
  logic [SW-1:0] rs_idx;
  logic          rs_in_range;
  logic          done_now;

  assign hdr_shift = {hdr_r[HDR_W-9:0], byte_r};
  assign cid_cur   = pend_init_r ? hdr_r[55:24] : hdr_r[39:8];
  assign cmd_cur   = hdr_r[22:16];
  assign bcnt_cur  = hdr_r[15:0];
  assign seq_cur   = hdr_r[7:0];

  assign idle_age    = now_r - last_r[idx];
  assign idx_expired = idle_age > {16'd0, idle_timeout};
  assign idx_match   = act_slot_r[idx] && (id_r[idx] == cid_cur);
  assign target      = found_r ? hit_r : pick_r;

  // status back to the controller
  always_comb begin
    stat.act        = act_r;
    stat.need_dec   = (pos_r == POS_INIT_HDR && hdr_shift[23]) ||
                      (pos_r == POS_CONT_HDR && !byte_r[7]);
    stat.is_end     = (pos_r == POS_LAST);
    stat.is_init    = pend_init_r;
    stat.cid_zero   = (cid_cur == 32'd0);
    stat.len_over   = CW'(bcnt_cur) > CW'(BUFFER_BYTES);
    stat.found_now  = found_r || idx_match;
    stat.picked_now = picked_r || idx_expired;
    stat.alloc_stop = !act_slot_r[idx];
    stat.out_free   = !out_valid_r || out_tready;
  end

  // payload write for the current packet byte
  assign store_en = cmd.exec && (act_r == ACT_BYTE) &&
                    (((dec_r == DEC_INIT) && (pos_r >= POS_INIT_DATA)) ||
                     ((dec_r == DEC_CONT) && (pos_r >= POS_CONT_DATA))) &&
                    (rx_r[dslot_r] < total_r[dslot_r]) &&
                    (CW'(rx_r[dslot_r]) < CW'(BUFFER_BYTES));
  assign mem_we   = store_en;
  assign waddr    = AW'(int'(dslot_r) * BUFFER_BYTES + int'(rx_r[dslot_r]));

  // payload read
  assign rs_idx      = SW'(rslot_r);
  assign rs_in_range = (5'(rslot_r) < 5'(CHANNEL_SLOTS));
  assign mem_re      = cmd.exec && (act_r == ACT_READ);
  assign raddr       = AW'(int'(rs_idx) * BUFFER_BYTES + int'(roff_r));

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= byte_r;
    if (mem_re) rd_data_r <= mem[raddr];
  end

  assign done_now = ((dec_r == DEC_INIT) || (dec_r == DEC_CONT)) &&
                    (rx_r[dslot_r] >= total_r[dslot_r]);

  // item latch, packet state, table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= ACT_BYTE;
      byte_r      <= '0;
      rslot_r     <= '0;
      roff_r      <= '0;
      pos_r       <= '0;
      hdr_r       <= '0;
      pend_init_r <= 1'b0;
      dec_r       <= DEC_NONE;
      dslot_r     <= '0;
      derr_r      <= '0;
      dch_r       <= '0;
      now_r       <= '0;
      found_r     <= 1'b0;
      picked_r    <= 1'b0;
      hit_r       <= '0;
      pick_r      <= '0;
      rd_ok_r     <= 1'b0;
      for (int i = 0; i < CHANNEL_SLOTS; i++) begin
        act_slot_r[i] <= 1'b0;
        id_r[i]       <= '0;
        cmd_r[i]      <= '0;
        total_r[i]    <= '0;
        rx_r[i]       <= '0;
        seq_r[i]      <= '0;
        last_r[i]     <= '0;
      end
    end else begin
      // hold the accepted beat
      if (cmd.take) begin
        act_r   <= in_tuser;
        byte_r  <= in_tdata[7:0];
        rslot_r <= in_tdata[9:8];
        roff_r  <= in_tdata[20:10];
      end
      if (cmd.exec) begin
        case (act_r)
          ACT_TICK: now_r <= now_r + 32'd1;
          ACT_READ: begin
            rd_ok_r <= rs_in_range && (CW'(roff_r) < CW'(rx_r[rs_idx])) &&
                       (CW'(roff_r) < CW'(BUFFER_BYTES));
          end
          ACT_BYTE: begin
            if (pos_r < POS_INIT_DATA) hdr_r <= hdr_shift;
            if (pos_r == '0) dec_r <= DEC_NONE;
            pend_init_r <= (pos_r == POS_INIT_HDR);
            if (store_en) rx_r[dslot_r] <= rx_r[dslot_r] + 1'b1;
            pos_r <= pos_r + 1'b1;
          end
          default: ;
        endcase
      end
      // early checks on the captured header
      if (cmd.pre) begin
        dch_r    <= cid_cur;
        found_r  <= 1'b0;
        picked_r <= 1'b0;
        if (cid_cur == 32'd0) begin
          dec_r <= DEC_NONE;
        end else if (pend_init_r && stat.len_over) begin
          dec_r  <= DEC_ERROR;
          derr_r <= ERR_LENGTH;
        end
      end
      // look for the channel
      if (cmd.find && idx_match) begin
        found_r <= 1'b1;
        hit_r   <= idx;
      end
      // allocate: first free slot, evicting idle ones on the way
      if (cmd.alloc) begin
        if (!act_slot_r[idx]) begin
          picked_r <= 1'b1;
          pick_r   <= idx;
        end else if (idx_expired) begin
          picked_r        <= 1'b1;
          pick_r          <= idx;
          act_slot_r[idx] <= 1'b0;
          rx_r[idx]       <= '0;
        end
      end
      if (cmd.busy) begin
        dec_r  <= DEC_ERROR;
        derr_r <= ERR_BUSY;
      end
      // start a message in the chosen slot
      if (cmd.commit) begin
        act_slot_r[target] <= 1'b1;
        id_r[target]       <= cid_cur;
        cmd_r[target]      <= cmd_cur;
        total_r[target]    <= LW'(bcnt_cur);
        rx_r[target]       <= '0;
        seq_r[target]      <= '0;
        last_r[target]     <= now_r;
        dslot_r            <= target;
        dec_r              <= DEC_INIT;
      end
      // continuation sequence check
      if (cmd.cont_dec) begin
        if (!found_r || (rx_r[hit_r] == '0)) begin
          dec_r  <= DEC_ERROR;
          derr_r <= ERR_SEQ;
        end else if (seq_cur != seq_r[hit_r]) begin
          rx_r[hit_r] <= '0;
          dec_r       <= DEC_ERROR;
          derr_r      <= ERR_SEQ;
        end else begin
          seq_r[hit_r]  <= seq_r[hit_r] + 8'd1;
          last_r[hit_r] <= now_r;
          dslot_r       <= hit_r;
          dec_r         <= DEC_CONT;
        end
      end
      if (cmd.emit_end) dec_r <= DEC_NONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_kind_r  <= KIND_DONE;
      out_data_r  <= '0;
    end else begin
      if (out_tready) out_valid_r <= 1'b0;
      if (cmd.emit_read) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_READ;
        out_data_r  <= {2'b00, (rd_ok_r ? rd_data_r : 8'd0), 54'd0};
      end else if (cmd.emit_end) begin
        if (dec_r == DEC_ERROR) begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_ERROR;
          out_data_r  <= {30'd0, dch_r, derr_r};
        end else if (done_now) begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_DONE;
          out_data_r  <= {10'd0, 2'(dslot_r), 11'(total_r[dslot_r]),
                          cmd_r[dslot_r], dch_r, ERR_LENGTH};
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/ctaphid_packet_reassembler.sv =====
// Beats are taken one at a time; a new beat is not accepted until the last one is through.
// The header byte that decides an INIT or CONT frame waits on the table scan, one slot per cycle.
// Reset (synchronous, rst_n low) clears the channel table, packet state, clock and output;
// idle timeout returns to 1000 ms. The payload store is not cleared.
`include "ctaphid_packet_reassembler_defines.svh"

module ctaphid_packet_reassembler #(
  parameter int CHANNEL_SLOTS = cpr_pkg::DEF_CHANNEL_SLOTS,
  parameter int BUFFER_BYTES  = cpr_pkg::DEF_BUFFER_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // data_byte[7:0], read_slot[9:8], read_offset[20:10], zero fill
  input  logic [cpr_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // error_code[1:0], channel_id[33:2], command[40:34], message_length[51:41],
  // slot[53:52], read_byte[61:54], zero fill
  output logic [cpr_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind[1:0]
  output logic [1:0]                     out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import cpr_pkg::*;

  localparam int SW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

  cpr_cmd_t      cmd;
  cpr_stat_t     stat;
  logic [SW-1:0] idx;
  logic [15:0]   idle_timeout_r;
  logic          cfg_hit;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_IDLE_TIMEOUT) && (cfg_paddr[1:0] == 2'b00);
  assign cfg_prdata = cfg_hit ? {16'd0, idle_timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= TIMEOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      idle_timeout_r <= cfg_pwdata[15:0];
    end
  end

  cpr_ctrl #(
    .CHANNEL_SLOTS(CHANNEL_SLOTS),
    .SW(SW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat(stat),
    .cmd(cmd),
    .idx(idx)
  );

  cpr_dp #(
    .CHANNEL_SLOTS(CHANNEL_SLOTS),
    .BUFFER_BYTES(BUFFER_BYTES),
    .SW(SW)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .idx(idx),
    .stat(stat),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .idle_timeout(idle_timeout_r),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  `CPR_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `CPR_ASSERT_IMP(a_kind_known, clk, rst_n, out_tvalid, out_tuser != 2'd3)
  `CPR_ASSERT_IMP(a_read_clean, clk, rst_n, out_tvalid && out_tuser == KIND_READ,
                  out_tdata[53:0] == 54'd0)

endmodule

// ===== sim/ctaphid_packet_reassembler_tb.sv =====
`timescale 1ns/1ps
module ctaphid_packet_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpr_pkg::*;

  localparam int NSLOT    = DEF_CHANNEL_SLOTS;
  localparam int NBUF     = DEF_BUFFER_BYTES;
  localparam int IDLE_MAX = 6000;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [31:0] cid;
    logic [6:0]  cmd;
    logic [10:0] len;
    logic [1:0]  slot;
    logic [7:0]  rbyte;
  } rx_result_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser, out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  ctaphid_packet_reassembler u_dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // channel table mirror
  logic [15:0]  timeout_ms;
  logic [5:0]   pkt_pos;
  logic [55:0]  hdr_bytes;
  cpr_dec_t     pkt_dec;
  int           dec_slot;
  logic [1:0]   dec_err;
  logic [31:0]  dec_cid;
  logic [31:0]  clock_ms;
  bit           ch_live [NSLOT];
  logic [31:0]  ch_cid [NSLOT];
  logic [6:0]   ch_cmd [NSLOT];
  int           ch_total [NSLOT];
  int           ch_rcvd [NSLOT];
  logic [7:0]   ch_seq [NSLOT];
  logic [31:0]  ch_seen [NSLOT];
  logic [7:0]   payload [NSLOT][NBUF];

  rx_result_t results_due[$];
  int n_beats, n_results, n_done, n_errs, n_reads, n_fail, idle_cycles;
  int burst_left;
  bit gaps_on, hold_rx;
  int rx_mode;

  function automatic int lookup_channel(logic [31:0] cid);
    for (int i = 0; i < NSLOT; i++)
      if (ch_live[i] && ch_cid[i] == cid) return i;
    return -1;
  endfunction

  function automatic int claim_slot(logic [31:0] cid);
    int pick;
    pick = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!ch_live[i]) begin
        pick = i;
        break;
      end
      if (clock_ms - ch_seen[i] > {16'd0, timeout_ms}) begin
        pick = i;
        ch_live[i] = 1'b0;
        ch_rcvd[i] = 0;
      end
    end
    if (pick >= 0) begin
      ch_cid[pick] = cid;
      ch_live[pick] = 1'b1;
    end
    return pick;
  endfunction

  function automatic void decide_init_frame();
    logic [31:0] cid;
    int s;
    cid = hdr_bytes[55:24];
    dec_cid = cid;
    if (cid == 32'd0) begin
      pkt_dec = DEC_NONE;
      return;
    end
    if (hdr_bytes[15:0] > NBUF) begin
      pkt_dec = DEC_ERROR;
      dec_err = ERR_LENGTH;
      return;
    end
    s = lookup_channel(cid);
    if (s < 0) s = claim_slot(cid);
    if (s < 0) begin
      pkt_dec = DEC_ERROR;
      dec_err = ERR_BUSY;
      return;
    end
    ch_cmd[s] = hdr_bytes[22:16];
    ch_total[s] = hdr_bytes[15:0];
    ch_rcvd[s] = 0;
    ch_seq[s] = 8'd0;
    ch_seen[s] = clock_ms;
    dec_slot = s;
    pkt_dec = DEC_INIT;
  endfunction

  function automatic void decide_cont_frame();
    logic [31:0] cid;
    int s;
    cid = hdr_bytes[39:8];
    dec_cid = cid;
    if (cid == 32'd0) begin
      pkt_dec = DEC_NONE;
      return;
    end
    s = lookup_channel(cid);
    if (s < 0 || ch_rcvd[s] == 0) begin
      pkt_dec = DEC_ERROR;
      dec_err = ERR_SEQ;
      return;
    end
    if (hdr_bytes[7:0] != ch_seq[s]) begin
      ch_rcvd[s] = 0;
      pkt_dec = DEC_ERROR;
      dec_err = ERR_SEQ;
      return;
    end
    ch_seq[s] = ch_seq[s] + 8'd1;
    ch_seen[s] = clock_ms;
    dec_slot = s;
    pkt_dec = DEC_CONT;
  endfunction

  // advance the table by one accepted beat and queue what it yields
  function automatic void reassemble_beat(logic [1:0] act, logic [7:0] b,
                                          logic [1:0] rs, logic [10:0] ro);
    rx_result_t r;
    int p;
    cpr_dec_t d;
    r = '{default: '0};
    if (act == ACT_TICK) begin
      clock_ms++;
      return;
    end
    if (act == ACT_READ) begin
      r.kind = KIND_READ;
      if (ro < ch_rcvd[rs]) r.rbyte = payload[rs][ro];
      results_due.push_back(r);
      return;
    end
    if (act != ACT_BYTE) return;
    p = pkt_pos;
    if (p < POS_INIT_DATA) begin
      hdr_bytes = {hdr_bytes[47:0], b};
      if (p == 0) pkt_dec = DEC_NONE;
      if (p == POS_CONT_HDR && !b[7]) decide_cont_frame();
      if (p == POS_INIT_HDR && hdr_bytes[23]) decide_init_frame();
    end
    if ((pkt_dec == DEC_INIT && p >= POS_INIT_DATA) ||
        (pkt_dec == DEC_CONT && p >= POS_CONT_DATA)) begin
      if (ch_rcvd[dec_slot] < ch_total[dec_slot]) begin
        payload[dec_slot][ch_rcvd[dec_slot]] = b;
        ch_rcvd[dec_slot]++;
      end
    end
    pkt_pos = pkt_pos + 6'd1;
    if (p != POS_LAST) return;
    d = pkt_dec;
    pkt_dec = DEC_NONE;
    if (d == DEC_ERROR) begin
      r.kind = KIND_ERROR;
      r.err = dec_err;
      r.cid = dec_cid;
      results_due.push_back(r);
    end else if ((d == DEC_INIT || d == DEC_CONT) &&
                 ch_rcvd[dec_slot] >= ch_total[dec_slot]) begin
      r.kind = KIND_DONE;
      r.cid = dec_cid;
      r.cmd = ch_cmd[dec_slot];
      r.len = ch_total[dec_slot];
      r.slot = dec_slot;
      results_due.push_back(r);
    end
  endfunction

  // offer one beat, hold it until taken, then maybe open a gap
  task automatic send_beat(logic [1:0] act, logic [7:0] b, logic [1:0] rs = 0,
                           logic [10:0] ro = 0);
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {3'd0, ro, rs, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    reassemble_beat(act, b, rs, ro);
    n_beats++;
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic random_side_beat();
    if ($urandom_range(0, 1)) send_beat(ACT_TICK, $urandom);
    else send_beat(ACT_READ, $urandom, $urandom, $urandom_range(0, NBUF - 1));
  endtask

  // one 64-byte report; side beats may fall between its bytes
  task automatic send_packet(bit init, logic [31:0] cid, logic [7:0] cmd_or_seq,
                             logic [15:0] bcnt, int side_pct = 0);
    logic [7:0] pkt [64];
    for (int i = 0; i < 64; i++) pkt[i] = $urandom;
    {pkt[0], pkt[1], pkt[2], pkt[3]} = cid;
    if (init) begin
      pkt[4] = cmd_or_seq | 8'h80;
      {pkt[5], pkt[6]} = bcnt;
    end else begin
      pkt[4] = cmd_or_seq & 8'h7f;
    end
    for (int i = 0; i < 64; i++) begin
      if ($urandom_range(0, 99) < side_pct) random_side_beat();
      send_beat(ACT_BYTE, pkt[i]);
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(ACT_TICK, $urandom);
  endtask

  // drop valid and wait until every queued result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 8) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'd4 * REG_IDLE_TIMEOUT;
    cfg_pwdata <= {16'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    timeout_ms = v;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[15:0] !== v) begin
      $error("idle_timeout_ms: expected %0d, got %0d", v, cfg_prdata[15:0]);
      n_fail++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // full-rate single- and multi-packet messages, reads and the error paths
  task automatic test_messages();
    gaps_on = 0;
    send_packet(1, 32'h11223344, 8'h03, 16'd5);
    send_beat(ACT_READ, 8'h00, 2'd0, 11'd0);
    send_beat(ACT_READ, 8'h00, 2'd0, 11'd4);
    send_beat(ACT_READ, 8'h00, 2'd0, 11'd5);
    send_beat(ACT_READ, 8'hff, 2'd3, 11'd1279);
    send_beat(2'd3, 8'hff, 2'd3, 11'h7ff);
    send_packet(1, 32'd0, 8'h7f, 16'd2);
    send_packet(0, 32'd0, 8'h00, 16'd0);
    send_packet(1, 32'hffffffff, 8'h7f, 16'd1281);
    send_packet(1, 32'hffffffff, 8'h7f, 16'hffff);
    send_packet(1, 32'hffffffff, 8'h00, 16'd0);
    send_packet(1, 32'h00000001, 8'h10, 16'd100);
    send_packet(0, 32'h00000001, 8'd0, 0);
    send_beat(ACT_READ, 8'h00, 2'd1, 11'd99);
    send_packet(0, 32'h00000001, 8'd1, 0);
    send_packet(0, 32'h00000001, 8'd5, 0);
    send_packet(0, 32'h00000001, 8'd2, 0);
    send_packet(0, 32'h0badcafe, 8'd0, 0);
    send_packet(1, 32'h11223344, 8'h01, 16'd1280);
    for (int k = 0; k < 22; k++) send_packet(0, 32'h11223344, k, 0);
    send_beat(ACT_READ, 8'h00, 2'd0, 11'd1279);
    drain();
  endtask

  // fill the table, then let idle slots age out under several timeouts
  task automatic test_eviction();
    gaps_on = 1;
    for (int c = 1; c <= NSLOT + 1; c++) send_packet(1, 32'h100 + c, c, 16'd70);
    send_ticks(3);
    send_packet(1, 32'h200, 8'h05, 16'd3);
    drain();
    write_timeout(16'd0);
    send_packet(1, 32'h300, 8'h06, 16'd3);
    send_ticks(2);
    send_packet(1, 32'h301, 8'h07, 16'd3, 30);
    drain();
    write_timeout(16'd65535);
    send_ticks(4);
    send_packet(1, 32'h302, 8'h08, 16'd3);
    drain();
    write_timeout(16'd2);
    send_ticks(3);
    send_packet(1, 32'h303, 8'h09, 16'd3, 20);
    drain();
  endtask

  // mostly proper messages over a small channel pool, with noise mixed in
  task automatic test_random(logic [15:0] tmo, int budget);
    logic [31:0] pool [6] = '{32'd1, 32'd2, 32'd3, 32'h80000004, 32'hffffffff, 32'd6};
    logic [31:0] cid;
    int stop_at, bcnt, n_cont, sel;
    write_timeout(tmo);
    gaps_on = 1;
    stop_at = n_beats + budget;
    while (n_beats < stop_at) begin
      cid = ($urandom_range(0, 30) == 0) ? 32'd0 : pool[$urandom_range(0, 5)];
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        sel = $urandom_range(0, 99);
        bcnt = sel < 60 ? $urandom_range(0, 57) : sel < 95 ? $urandom_range(58, 300) :
               sel < 98 ? $urandom_range(301, NBUF) : $urandom_range(NBUF + 1, 65535);
        send_packet(1, cid, $urandom, bcnt, 8);
        n_cont = bcnt <= 57 ? 0 : (bcnt - 57 + 58) / 59;
        for (int k = 0; k < n_cont; k++) begin
          if ($urandom_range(0, 19) == 0) send_packet(0, cid, $urandom_range(0, 127), 0, 8);
          else send_packet(0, cid, k, 0, 8);
        end
        if ($urandom_range(0, 3) == 0) send_packet(0, cid, n_cont, 0, 8);
      end else if (sel < 85) begin
        send_packet(0, cid, $urandom_range(0, 127), 0, 8);
      end else if (sel < 92) begin
        send_ticks($urandom_range(1, 3 * tmo + 3 > 40 ? 40 : 3 * tmo + 3));
      end else begin
        repeat ($urandom_range(1, 10)) random_side_beat();
      end
    end
    drain();
  endtask

  task automatic hold_receiver(int cycles);
    hold_rx = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_rx = 1'b0;
  endtask

  // stall the result side for a long stretch while reads keep coming
  task automatic test_backpressure();
    gaps_on = 0;
    fork
      hold_receiver(400);
      repeat (60) send_beat(ACT_READ, $urandom, $urandom, $urandom_range(0, 200));
    join
    drain();
  endtask

  // result side: ready follows a randomly chosen stall pattern, forced low while held
  int rx_cyc;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 200 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_rx) out_tready <= 1'b0;
    else case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 3) != 0;
      2: out_tready <= (rx_cyc % 7) < 3;
      default: out_tready <= $urandom_range(0, 1);
    endcase
  end

  // compare each result beat against the oldest prediction
  always @(posedge clk) begin
    rx_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", out_tuser);
        n_fail++;
      end else begin
        e = results_due.pop_front();
        case (e.kind)
          KIND_DONE: n_done++;
          KIND_ERROR: n_errs++;
          default: n_reads++;
        endcase
        if (out_tuser !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_tuser); n_fail++;
        end
        if (out_tdata[1:0] !== e.err) begin
          $error("error_code: expected %0d, got %0d", e.err, out_tdata[1:0]); n_fail++;
        end
        if (out_tdata[33:2] !== e.cid) begin
          $error("channel_id: expected %h, got %h", e.cid, out_tdata[33:2]); n_fail++;
        end
        if (out_tdata[40:34] !== e.cmd) begin
          $error("command: expected %h, got %h", e.cmd, out_tdata[40:34]); n_fail++;
        end
        if (out_tdata[51:41] !== e.len) begin
          $error("message_length: expected %0d, got %0d", e.len, out_tdata[51:41]);
          n_fail++;
        end
        if (out_tdata[53:52] !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, out_tdata[53:52]); n_fail++;
        end
        if (out_tdata[61:54] !== e.rbyte) begin
          $error("read_byte: expected %h, got %h", e.rbyte, out_tdata[61:54]); n_fail++;
        end
      end
    end
  end

  // end the run if neither side moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_rx = 1'b0;
    rx_mode = 0;
    rx_cyc = 0;
    idle_cycles = 0;
    burst_left = 0;
    timeout_ms = TIMEOUT_RESET;
    pkt_pos = '0;
    hdr_bytes = '0;
    pkt_dec = DEC_NONE;
    dec_slot = 0;
    dec_err = '0;
    dec_cid = '0;
    clock_ms = '0;
    for (int i = 0; i < NSLOT; i++) begin
      ch_live[i] = 0; ch_cid[i] = 0; ch_cmd[i] = 0; ch_total[i] = 0;
      ch_rcvd[i] = 0; ch_seq[i] = 0; ch_seen[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_messages();
    test_eviction();
    test_backpressure();
    test_random(16'd20, 450);
    test_random(16'd0, 300);
    test_random(16'd65535, 300);
    test_random(TIMEOUT_RESET, 250);
    $display("Covered %0d input beats: %0d completions, %0d errors, %0d payload reads,",
             n_beats, n_done, n_errs, n_reads);
    $display("  timeouts 0..65535, slot eviction, back-pressure and sender gaps.");
    if (n_fail == 0 && results_due.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
